// ----- hdl/wbps_pkg.sv -----
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern search core.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

    // pattern storage and offset widths
    localparam int MAX_PATTERN = 256;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 9;
    localparam int OFFSET_BITS = 32;
    localparam int OFFSET_W    = 32;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic             scan;
        logic             clear;
        logic             load;
        logic [IDX_W-1:0] load_index;
        logic [7:0]       load_byte;
        logic             load_wild;
        logic [7:0]       data_byte;
    } cell_ctrl_t;

    // one result item
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

    // result queue status seen by the control logic
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- hdl/wbps_cell.sv -----
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: stored byte, wildcard mark and prefix match bit.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell
    import wbps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire logic             prev_match,
    output logic                  match_bit,
    output logic                  match_next
);

    logic [7:0] value_reg;
    logic       wild_reg;
    logic       match_reg;
    logic       accepts;

    // pattern entry, undefined until loaded
    always_ff @(posedge aclk) begin
        if (ctrl.load && (ctrl.load_index == cell_index)) begin
            value_reg <= ctrl.load_byte;
            wild_reg  <= ctrl.load_wild;
        end
    end

    assign accepts    = wild_reg || (value_reg == ctrl.data_byte);
    assign match_next = prev_match & accepts;

    // prefix bit, shifted in from the left neighbor on each scanned byte and cleared on a region's last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.scan) begin
            match_reg <= ctrl.clear ? 1'b0 : match_next;
        end
    end

    assign match_bit = match_reg;

endmodule

`default_nettype wire

// ----- hdl/wbps_out_queue.sv -----
// ----------------------------------------------------------------------------
// wbps_out_queue
// Two-entry result queue between the scan logic and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_out_queue
    import wbps_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output result_t      head,
    output queue_status_t status
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

// ----- hdl/wildcard_byte_pattern_search_core.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core
// Streaming search for the first match of a byte pattern with wildcards.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while s_ready is high, so a byte
// stream runs through it at one byte per cycle, whatever the pattern length,
// while the result channel keeps up. Each item is finished in the cycle it is
// transferred: its result, if any, is written into a two-entry result queue
// that feeds the m_ channel. The rate is set by the row of 256 cells, one per
// pattern position, which all update their prefix match bit in parallel on
// each scanned byte (shift-and). s_ready drops only when both result queue
// entries are held by a stalled result channel. Load items (command 0) write
// one pattern entry and give no result; scan items (command 1) give a found
// result with the start offset when the first full match completes, or a
// not-found result when the region's last byte arrives without a match. The
// last byte clears the scan state for the next region. Pattern entries have
// no reset value and must be loaded before they are used. The user must write
// the pattern length register via cfg_wr_en / cfg_wr_data only while the core
// is idle, not enforced by the core; 0 acts as 1, values above 256 act as 256.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_search_core
    import wbps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // pattern length register
    input  wire logic                cfg_wr_en,
    input  wire logic [LEN_W-1:0]    cfg_wr_data,

    // item channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_command,
    input  wire logic [7:0]          s_entry_index,
    input  wire logic [7:0]          s_entry_byte,
    input  wire logic                s_entry_is_wildcard,
    input  wire logic [7:0]          s_data_byte,
    input  wire logic                s_last_byte,

    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_found,
    output logic [OFFSET_W-1:0]      m_match_offset
);

    // ------------------------------------------------------------------
    // pattern length, held as the index of the last pattern position
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] tail_idx_reg, tail_idx_next;

    always_comb begin
        tail_idx_next = tail_idx_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                tail_idx_next = '0;
            end else if (cfg_wr_data > LEN_W'(MAX_PATTERN)) begin
                tail_idx_next = IDX_W'(MAX_PATTERN - 1);
            end else begin
                tail_idx_next = IDX_W'(cfg_wr_data - LEN_W'(1));
            end
        end
    end

    // ------------------------------------------------------------------
    // item transfer and scan control
    // ------------------------------------------------------------------
    queue_status_t q_status;
    result_t       q_head;
    result_t       push_data;
    cell_ctrl_t    ctrl;
    logic          s_xfer;
    logic          scan_xfer;
    logic          push;
    logic          report;
    logic          tail_hit;

    logic [OFFSET_BITS-1:0] byte_count_reg, byte_count_next;
    logic                   reported_reg, reported_next;

    logic [MAX_PATTERN-1:0] match_bits;
    logic [MAX_PATTERN-1:0] match_next_bits;

    assign s_ready   = !q_status.full;
    assign s_xfer    = s_valid && s_ready;
    assign scan_xfer = s_xfer && (s_command == CMD_SCAN);

    // broadcast to the cell row
    assign ctrl.scan       = scan_xfer;
    assign ctrl.clear      = s_last_byte;
    assign ctrl.load       = s_xfer && (s_command == CMD_LOAD);
    assign ctrl.load_index = s_entry_index;
    assign ctrl.load_byte  = s_entry_byte;
    assign ctrl.load_wild  = s_entry_is_wildcard;
    assign ctrl.data_byte  = s_data_byte;

    // updated prefix bit at the last pattern position
    assign tail_hit = match_next_bits[tail_idx_reg];
    assign report   = !reported_reg && tail_hit;

    always_comb begin
        push                   = 1'b0;
        push_data.found        = 1'b0;
        push_data.match_offset = '0;
        reported_next          = reported_reg;
        byte_count_next        = byte_count_reg;
        if (scan_xfer) begin
            if (report) begin
                // first full match: start offset is count minus pattern length plus one
                push                   = 1'b1;
                push_data.found        = 1'b1;
                push_data.match_offset = OFFSET_W'(byte_count_reg
                                         - OFFSET_BITS'(tail_idx_reg));
            end else if (s_last_byte && !reported_reg) begin
                // region ended without a match
                push = 1'b1;
            end
            if (s_last_byte) begin
                reported_next   = 1'b0;
                byte_count_next = '0;
            end else begin
                reported_next   = reported_reg || report;
                byte_count_next = byte_count_reg + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_idx_reg   <= '0;
            byte_count_reg <= '0;
            reported_reg   <= 1'b0;
        end else begin
            tail_idx_reg   <= tail_idx_next;
            byte_count_reg <= byte_count_next;
            reported_reg   <= reported_next;
        end
    end

    // ------------------------------------------------------------------
    // cell row: cell 0 always sees a matched empty prefix on its left
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        logic prev_match;
        if (i == 0) begin : g_head
            assign prev_match = 1'b1;
        end else begin : g_body
            assign prev_match = match_bits[i-1];
        end

        wbps_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .cell_index (IDX_W'(i)),
            .prev_match (prev_match),
            .match_bit  (match_bits[i]),
            .match_next (match_next_bits[i])
        );
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    wbps_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_valid && m_ready),
        .head      (q_head),
        .status    (q_status)
    );

    assign m_valid        = !q_status.empty;
    assign m_found        = q_head.found;
    assign m_match_offset = q_head.match_offset;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a result is never written into a full queue
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("result written into full queue");

    // the last byte of a region leaves the scan state cleared
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_xfer && s_last_byte) |=> (!reported_reg && byte_count_reg == '0))
        else $error("scan state not cleared after last byte");

    // the match flag only rises after a found result was written into the queue
    a_report_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(reported_reg) |-> $past(push && push_data.found))
        else $error("match flagged without a found result");

    // no further result is written once a match was reported
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && reported_reg) |-> 1'b0)
        else $error("second result in one region");

endmodule

`default_nettype wire
